@@ src/tacc_pkg.sv @@
// shared types, codes and the operation sequence for the transform accumulator
// used by tacc_mac and transform_accumulator_top; depends on nothing
`default_nettype none

package tacc_pkg;

  localparam int DATA_W         = 32;
  localparam int ACC_W          = 68;
  localparam int STEP_W         = 5;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int SHIFT_TS  = 16;
  localparam int SHIFT_T   = 29;
  localparam int SHIFT_ROT = 30;

  localparam logic signed [DATA_W-1:0] ONE_TS  = DATA_W'(65536);
  localparam logic signed [DATA_W-1:0] ONE_ROT = DATA_W'(1073741824);

  // operation codes
  localparam logic [1:0] FUNC_TRANSLATE = 2'd0;
  localparam logic [1:0] FUNC_SCALE     = 2'd1;
  localparam logic [1:0] FUNC_ROTATE    = 2'd2;

  // multiplier operand a: the argument components
  localparam logic [1:0] ASEL_X = 2'd0;
  localparam logic [1:0] ASEL_Y = 2'd1;
  localparam logic [1:0] ASEL_Z = 2'd2;
  localparam logic [1:0] ASEL_W = 2'd3;

  // multiplier operand b: stored state, cross product terms or one
  localparam logic [3:0] BSEL_QX  = 4'd0;
  localparam logic [3:0] BSEL_QY  = 4'd1;
  localparam logic [3:0] BSEL_QZ  = 4'd2;
  localparam logic [3:0] BSEL_QW  = 4'd3;
  localparam logic [3:0] BSEL_VX  = 4'd4;
  localparam logic [3:0] BSEL_VY  = 4'd5;
  localparam logic [3:0] BSEL_VZ  = 4'd6;
  localparam logic [3:0] BSEL_TX  = 4'd7;
  localparam logic [3:0] BSEL_TY  = 4'd8;
  localparam logic [3:0] BSEL_TZ  = 4'd9;
  localparam logic [3:0] BSEL_SX  = 4'd10;
  localparam logic [3:0] BSEL_SY  = 4'd11;
  localparam logic [3:0] BSEL_SZ  = 4'd12;
  localparam logic [3:0] BSEL_ONE = 4'd13;

  // write-back destinations
  localparam logic [3:0] DST_TX = 4'd0;
  localparam logic [3:0] DST_TY = 4'd1;
  localparam logic [3:0] DST_TZ = 4'd2;
  localparam logic [3:0] DST_SX = 4'd3;
  localparam logic [3:0] DST_SY = 4'd4;
  localparam logic [3:0] DST_SZ = 4'd5;
  localparam logic [3:0] DST_QX = 4'd6;
  localparam logic [3:0] DST_QY = 4'd7;
  localparam logic [3:0] DST_QZ = 4'd8;
  localparam logic [3:0] DST_QW = 4'd9;
  localparam logic [3:0] DST_PX = 4'd10;
  localparam logic [3:0] DST_PY = 4'd11;
  localparam logic [3:0] DST_PZ = 4'd12;

  // rounding point of a sum
  localparam logic [1:0] SHF_16 = 2'd0;
  localparam logic [1:0] SHF_29 = 2'd1;
  localparam logic [1:0] SHF_30 = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       neg;
    logic       first;
    logic       last;
    logic [3:0] dst;
    logic [1:0] shf;
  } mac_op_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] dst;
  } wb_t;

  typedef struct packed {
    mac_op_t    op;
    logic [1:0] asel;
    logic [3:0] bsel;
    logic       add_v;
    logic       fin;
  } uop_t;

  function automatic uop_t mk_uop(input logic [1:0] asel, input logic [3:0] bsel,
                                  input int neg, input int first, input int last,
                                  input int add_v, input logic [3:0] dst,
                                  input logic [1:0] shf, input int fin);
    uop_t u;
    u.op.valid = 1'b1;
    u.op.neg   = neg[0];
    u.op.first = first[0];
    u.op.last  = last[0];
    u.op.dst   = dst;
    u.op.shf   = shf;
    u.asel     = asel;
    u.bsel     = bsel;
    u.add_v    = add_v[0];
    u.fin      = fin[0];
    return u;
  endfunction

  // one product per step; fin marks the last step of an operation
  function automatic uop_t tacc_uop(input logic [1:0] func, input logic [STEP_W-1:0] step);
    uop_t u;
    u = '0;
    u.fin = 1'b1;
    unique case (func)
      FUNC_TRANSLATE: begin
        // v + a, as a * 1.0 rounded at 16 plus v
        unique case (step)
          5'd0: u = mk_uop(ASEL_X, BSEL_ONE, 0, 1, 1, 1, DST_TX, SHF_16, 0);
          5'd1: u = mk_uop(ASEL_Y, BSEL_ONE, 0, 1, 1, 1, DST_TY, SHF_16, 0);
          5'd2: u = mk_uop(ASEL_Z, BSEL_ONE, 0, 1, 1, 1, DST_TZ, SHF_16, 1);
          default: u = u;
        endcase
      end
      FUNC_SCALE: begin
        unique case (step)
          5'd0: u = mk_uop(ASEL_X, BSEL_VX, 0, 1, 1, 0, DST_TX, SHF_16, 0);
          5'd1: u = mk_uop(ASEL_X, BSEL_SX, 0, 1, 1, 0, DST_SX, SHF_16, 0);
          5'd2: u = mk_uop(ASEL_Y, BSEL_VY, 0, 1, 1, 0, DST_TY, SHF_16, 0);
          5'd3: u = mk_uop(ASEL_Y, BSEL_SY, 0, 1, 1, 0, DST_SY, SHF_16, 0);
          5'd4: u = mk_uop(ASEL_Z, BSEL_VZ, 0, 1, 1, 0, DST_TZ, SHF_16, 0);
          5'd5: u = mk_uop(ASEL_Z, BSEL_SZ, 0, 1, 1, 0, DST_SZ, SHF_16, 1);
          default: u = u;
        endcase
      end
      FUNC_ROTATE: begin
        unique case (step)
          // doubled cross product q x v
          5'd0:  u = mk_uop(ASEL_Y, BSEL_VZ, 0, 1, 0, 0, DST_PX, SHF_29, 0);
          5'd1:  u = mk_uop(ASEL_Z, BSEL_VY, 1, 0, 1, 0, DST_PX, SHF_29, 0);
          5'd2:  u = mk_uop(ASEL_Z, BSEL_VX, 0, 1, 0, 0, DST_PY, SHF_29, 0);
          5'd3:  u = mk_uop(ASEL_X, BSEL_VZ, 1, 0, 1, 0, DST_PY, SHF_29, 0);
          5'd4:  u = mk_uop(ASEL_X, BSEL_VY, 0, 1, 0, 0, DST_PZ, SHF_29, 0);
          5'd5:  u = mk_uop(ASEL_Y, BSEL_VX, 1, 0, 1, 0, DST_PZ, SHF_29, 0);
          // quaternion product new times old
          5'd6:  u = mk_uop(ASEL_W, BSEL_QX, 0, 1, 0, 0, DST_QX, SHF_30, 0);
          5'd7:  u = mk_uop(ASEL_X, BSEL_QW, 0, 0, 0, 0, DST_QX, SHF_30, 0);
          5'd8:  u = mk_uop(ASEL_Y, BSEL_QZ, 0, 0, 0, 0, DST_QX, SHF_30, 0);
          5'd9:  u = mk_uop(ASEL_Z, BSEL_QY, 1, 0, 1, 0, DST_QX, SHF_30, 0);
          5'd10: u = mk_uop(ASEL_W, BSEL_QY, 0, 1, 0, 0, DST_QY, SHF_30, 0);
          5'd11: u = mk_uop(ASEL_X, BSEL_QZ, 1, 0, 0, 0, DST_QY, SHF_30, 0);
          5'd12: u = mk_uop(ASEL_Y, BSEL_QW, 0, 0, 0, 0, DST_QY, SHF_30, 0);
          5'd13: u = mk_uop(ASEL_Z, BSEL_QX, 0, 0, 1, 0, DST_QY, SHF_30, 0);
          5'd14: u = mk_uop(ASEL_W, BSEL_QZ, 0, 1, 0, 0, DST_QZ, SHF_30, 0);
          5'd15: u = mk_uop(ASEL_X, BSEL_QY, 0, 0, 0, 0, DST_QZ, SHF_30, 0);
          5'd16: u = mk_uop(ASEL_Y, BSEL_QX, 1, 0, 0, 0, DST_QZ, SHF_30, 0);
          5'd17: u = mk_uop(ASEL_Z, BSEL_QW, 0, 0, 1, 0, DST_QZ, SHF_30, 0);
          5'd18: u = mk_uop(ASEL_W, BSEL_QW, 0, 1, 0, 0, DST_QW, SHF_30, 0);
          5'd19: u = mk_uop(ASEL_X, BSEL_QX, 1, 0, 0, 0, DST_QW, SHF_30, 0);
          5'd20: u = mk_uop(ASEL_Y, BSEL_QY, 1, 0, 0, 0, DST_QW, SHF_30, 0);
          5'd21: u = mk_uop(ASEL_Z, BSEL_QZ, 1, 0, 1, 0, DST_QW, SHF_30, 0);
          // v + w*t + q x t
          5'd22: u = mk_uop(ASEL_W, BSEL_TX, 0, 1, 0, 1, DST_TX, SHF_30, 0);
          5'd23: u = mk_uop(ASEL_Y, BSEL_TZ, 0, 0, 0, 1, DST_TX, SHF_30, 0);
          5'd24: u = mk_uop(ASEL_Z, BSEL_TY, 1, 0, 1, 1, DST_TX, SHF_30, 0);
          5'd25: u = mk_uop(ASEL_W, BSEL_TY, 0, 1, 0, 1, DST_TY, SHF_30, 0);
          5'd26: u = mk_uop(ASEL_Z, BSEL_TX, 0, 0, 0, 1, DST_TY, SHF_30, 0);
          5'd27: u = mk_uop(ASEL_X, BSEL_TZ, 1, 0, 1, 1, DST_TY, SHF_30, 0);
          5'd28: u = mk_uop(ASEL_W, BSEL_TZ, 0, 1, 0, 1, DST_TZ, SHF_30, 0);
          5'd29: u = mk_uop(ASEL_X, BSEL_TY, 0, 0, 0, 1, DST_TZ, SHF_30, 0);
          5'd30: u = mk_uop(ASEL_Y, BSEL_TX, 1, 0, 1, 1, DST_TZ, SHF_30, 1);
          default: u = u;
        endcase
      end
      default: u = u;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ src/tacc_mac.sv @@
// shared multiply, accumulate, round and saturate unit of the transform accumulator
// depends on tacc_pkg
`default_nettype none

module tacc_mac #(
  parameter int WORD_WIDTH = tacc_pkg::WORD_WIDTH_DEF
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire tacc_pkg::mac_op_t                    op_i,
  input  wire logic signed [tacc_pkg::DATA_W-1:0]   a_i,
  input  wire logic signed [tacc_pkg::DATA_W-1:0]   b_i,
  input  wire logic signed [tacc_pkg::DATA_W-1:0]   addend_i,
  output tacc_pkg::wb_t                             wb_o,
  output logic signed [tacc_pkg::DATA_W-1:0]        wb_data_o,
  output logic                                      wb_sat_o
);
  import tacc_pkg::*;

  localparam int SatBits = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
  localparam logic signed [ACC_W-1:0] SatMax = (ACC_W'(1) << (SatBits - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SatMin = -SatMax - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Half16 = ACC_W'(1) << (SHIFT_TS - 1);
  localparam logic signed [ACC_W-1:0] Half29 = ACC_W'(1) << (SHIFT_T - 1);
  localparam logic signed [ACC_W-1:0] Half30 = ACC_W'(1) << (SHIFT_ROT - 1);

  logic signed [2*DATA_W-1:0] prod_q;
  mac_op_t                    op1_q;
  logic signed [DATA_W-1:0]   add1_q;
  logic signed [DATA_W-1:0]   add2_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ACC_W-1:0]    prod_ext, base, half;
  logic                       wb_valid_q;
  logic [3:0]                 wb_dst_q;
  logic [1:0]                 wb_shf_q;
  logic signed [ACC_W-1:0]    shifted, value;

  // stage 1: the multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q <= '0;
    end else begin
      op1_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    add1_q <= addend_i;
  end

  // stage 2: accumulate, the rounding half is preloaded on the first term
  always_comb begin
    unique case (op1_q.shf)
      SHF_16:  half = Half16;
      SHF_29:  half = Half29;
      default: half = Half30;
    endcase
    prod_ext = ACC_W'(prod_q);
    base     = op1_q.first ? half : acc_q;
    acc_d    = op1_q.neg ? (base - prod_ext) : (base + prod_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else begin
      wb_valid_q <= op1_q.valid & op1_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op1_q.valid) begin
      acc_q    <= acc_d;
      wb_dst_q <= op1_q.dst;
      wb_shf_q <= op1_q.shf;
      if (op1_q.first) begin
        add2_q <= add1_q;
      end
    end
  end

  // stage 3: floor shift, add the carried vector term, saturate
  always_comb begin
    unique case (wb_shf_q)
      SHF_16:  shifted = acc_q >>> SHIFT_TS;
      SHF_29:  shifted = acc_q >>> SHIFT_T;
      default: shifted = acc_q >>> SHIFT_ROT;
    endcase
    value = shifted + ACC_W'(add2_q);
    priority if (value > SatMax) begin
      wb_data_o = SatMax[DATA_W-1:0];
      wb_sat_o  = wb_valid_q;
    end else if (value < SatMin) begin
      wb_data_o = SatMin[DATA_W-1:0];
      wb_sat_o  = wb_valid_q;
    end else begin
      wb_data_o = value[DATA_W-1:0];
      wb_sat_o  = 1'b0;
    end
    wb_o.valid = wb_valid_q;
    wb_o.dst   = wb_dst_q;
  end

endmodule

`default_nettype wire

@@ src/transform_accumulator_top.sv @@
// top level of the transform accumulator: state, sequencer and operand selection
// depends on tacc_pkg and tacc_mac
`default_nettype none

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+-------------------------------------
// in       | input     | in_valid_i / in_stall_o    | func_i, arg_x_i..arg_w_i
// out      | output    | out_valid_o / out_stall_i  | trans_*_o, scl_*_o, rot_*_o, overflow_o
//
// one transaction at a time: every product goes through one shared 32x32 multiplier,
// one product per cycle, so the step count sets how long an operation takes
// the result follows the N steps of the program, N = 3 translate, 6 scale, 31 rotate,
// 1 for the unused code, and a drain through multiply, accumulate and round
// in_stall_o stays high until the result transaction completes
// reset gives the identity transform; out_stall_i holds the result, nothing else moves

module transform_accumulator_top #(
  parameter int WORD_WIDTH = tacc_pkg::WORD_WIDTH_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          func_i,
  input  wire logic signed [tacc_pkg::DATA_W-1:0]  arg_x_i,
  input  wire logic signed [tacc_pkg::DATA_W-1:0]  arg_y_i,
  input  wire logic signed [tacc_pkg::DATA_W-1:0]  arg_z_i,
  input  wire logic signed [tacc_pkg::DATA_W-1:0]  arg_w_i,
  output logic                                     out_valid_o,
  input  wire                                      out_stall_i,
  output logic signed [tacc_pkg::DATA_W-1:0]       trans_x_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       trans_y_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       trans_z_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       scl_x_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       scl_y_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       scl_z_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       rot_x_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       rot_y_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       rot_z_o,
  output logic signed [tacc_pkg::DATA_W-1:0]       rot_w_o,
  output logic                                     overflow_o
);
  import tacc_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic        drain_q;
  logic        accept;
  logic        ov_q;

  // captured transaction
  logic [1:0]               func_q;
  logic signed [DATA_W-1:0] ax_q, ay_q, az_q, aw_q;

  // accumulated transform
  logic signed [DATA_W-1:0] tx_q, ty_q, tz_q;
  logic signed [DATA_W-1:0] sx_q, sy_q, sz_q;
  logic signed [DATA_W-1:0] qx_q, qy_q, qz_q, qw_q;

  // rotate scratch: new quaternion (committed at the end) and doubled cross product
  logic signed [DATA_W-1:0] nqx_q, nqy_q, nqz_q, nqw_q;
  logic signed [DATA_W-1:0] px_q, py_q, pz_q;

  uop_t                     uop;
  mac_op_t                  mac_op;
  logic signed [DATA_W-1:0] op_a, op_b, addend;
  wb_t                      wb;
  logic signed [DATA_W-1:0] wb_data;
  logic                     wb_sat;
  logic                     commit;

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign commit      = (state_q == ST_DRAIN) & drain_q & (func_q == FUNC_ROTATE);

  // step program for the captured operation
  always_comb begin
    uop          = tacc_uop(func_q, step_q);
    mac_op       = uop.op;
    mac_op.valid = uop.op.valid & (state_q == ST_RUN);
  end

  // operand selection
  always_comb begin
    unique case (uop.asel)
      ASEL_X:  op_a = ax_q;
      ASEL_Y:  op_a = ay_q;
      ASEL_Z:  op_a = az_q;
      default: op_a = aw_q;
    endcase
    unique case (uop.bsel)
      BSEL_QX:  op_b = qx_q;
      BSEL_QY:  op_b = qy_q;
      BSEL_QZ:  op_b = qz_q;
      BSEL_QW:  op_b = qw_q;
      BSEL_VX:  op_b = tx_q;
      BSEL_VY:  op_b = ty_q;
      BSEL_VZ:  op_b = tz_q;
      BSEL_TX:  op_b = px_q;
      BSEL_TY:  op_b = py_q;
      BSEL_TZ:  op_b = pz_q;
      BSEL_SX:  op_b = sx_q;
      BSEL_SY:  op_b = sy_q;
      BSEL_SZ:  op_b = sz_q;
      default:  op_b = ONE_TS;
    endcase
    // old translation component rides along with the sum that replaces it
    addend = '0;
    if (uop.add_v) begin
      unique case (uop.op.dst)
        DST_TX:  addend = tx_q;
        DST_TY:  addend = ty_q;
        DST_TZ:  addend = tz_q;
        default: addend = '0;
      endcase
    end
  end

  tacc_mac #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (mac_op),
    .a_i       (op_a),
    .b_i       (op_b),
    .addend_i  (addend),
    .wb_o      (wb),
    .wb_data_o (wb_data),
    .wb_sat_o  (wb_sat)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_RUN;
      ST_RUN:   if (uop.fin) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q) state_d = ST_OUT;
      default:  if (!out_stall_i) state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      drain_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
        ov_q   <= 1'b0;
      end else begin
        if (state_q == ST_RUN) begin
          step_q <= step_q + STEP_W'(1);
        end
        if (wb_sat) begin
          ov_q <= 1'b1;
        end
      end
      drain_q <= (state_q == ST_DRAIN) & ~drain_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      ax_q   <= arg_x_i;
      ay_q   <= arg_y_i;
      az_q   <= arg_z_i;
      aw_q   <= arg_w_i;
    end
  end

  // architectural state, written back per component; the quaternion is committed whole
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q <= '0;
      ty_q <= '0;
      tz_q <= '0;
      sx_q <= ONE_TS;
      sy_q <= ONE_TS;
      sz_q <= ONE_TS;
      qx_q <= '0;
      qy_q <= '0;
      qz_q <= '0;
      qw_q <= ONE_ROT;
    end else begin
      if (wb.valid) begin
        unique case (wb.dst)
          DST_TX:  tx_q <= wb_data;
          DST_TY:  ty_q <= wb_data;
          DST_TZ:  tz_q <= wb_data;
          DST_SX:  sx_q <= wb_data;
          DST_SY:  sy_q <= wb_data;
          DST_SZ:  sz_q <= wb_data;
          default: ;
        endcase
      end
      if (commit) begin
        qx_q <= nqx_q;
        qy_q <= nqy_q;
        qz_q <= nqz_q;
        qw_q <= nqw_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb.valid) begin
      unique case (wb.dst)
        DST_QX:  nqx_q <= wb_data;
        DST_QY:  nqy_q <= wb_data;
        DST_QZ:  nqz_q <= wb_data;
        DST_QW:  nqw_q <= wb_data;
        DST_PX:  px_q  <= wb_data;
        DST_PY:  py_q  <= wb_data;
        DST_PZ:  pz_q  <= wb_data;
        default: ;
      endcase
    end
  end

  assign trans_x_o  = tx_q;
  assign trans_y_o  = ty_q;
  assign trans_z_o  = tz_q;
  assign scl_x_o    = sx_q;
  assign scl_y_o    = sy_q;
  assign scl_z_o    = sz_q;
  assign rot_x_o    = qx_q;
  assign rot_y_o    = qy_q;
  assign rot_z_o    = qz_q;
  assign rot_w_o    = qw_q;
  assign overflow_o = ov_q;

  // the drain must cover the whole unit: nothing left to write once the result shows
  a_no_late_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> !wb.valid)
    else $error("write-back after result presented");

  // write-backs only happen while an operation is in flight
  a_wb_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb.valid |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("write-back outside an operation");

  // the longest program has 31 steps
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= STEP_W'(30)))
    else $error("step counter ran past the program");

  // the x and w components of the quaternion change only on the commit of a rotate
  a_rot_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(commit) |-> ($stable(qx_q) && $stable(qw_q)))
    else $error("quaternion changed without commit");

endmodule

`default_nettype wire

@@ test/tb_transform_accumulator_top.sv @@
// self-checking testbench for transform_accumulator_top: directed and random operations,
// each result compared against an in-bench fixed-point model of the accumulated transform
// depends on tacc_pkg and transform_accumulator_top
`timescale 1ns / 1ps

module tb_transform_accumulator_top;

  import tacc_pkg::*;

  // func value that the block treats as a no-op
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SAT_W        = (WORD_WIDTH_DEF < 32) ? WORD_WIDTH_DEF : 32;
  localparam int REPORT_MAX   = 10;

  typedef logic signed [DATA_W-1:0] word_t;
  // wide enough for a sum of four full 32x32 products plus rounding
  typedef logic signed [95:0] wide_t;

  // one result transaction: translation, scale, quaternion, then the overflow flag
  typedef struct packed {
    logic [9:0][DATA_W-1:0] word;
    logic                   ovf;
  } xform_t;

  localparam word_t W_MAX = 32'sh7fffffff;
  localparam word_t W_MIN = 32'sh80000000;
  // cos(45 deg) in Q2.30, for a quarter turn
  localparam word_t Q45   = 32'sd759250125;

  string field_names[11] = '{"trans_x", "trans_y", "trans_z", "scl_x", "scl_y", "scl_z",
                             "rot_x", "rot_y", "rot_z", "rot_w", "overflow"};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  logic [1:0]  func_i      = '0;
  word_t       arg_x_i     = '0;
  word_t       arg_y_i     = '0;
  word_t       arg_z_i     = '0;
  word_t       arg_w_i     = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  word_t       trans_x_o, trans_y_o, trans_z_o;
  word_t       scl_x_o, scl_y_o, scl_z_o;
  word_t       rot_x_o, rot_y_o, rot_z_o, rot_w_o;
  logic        overflow_o;

  transform_accumulator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .arg_x_i     (arg_x_i),
    .arg_y_i     (arg_y_i),
    .arg_z_i     (arg_z_i),
    .arg_w_i     (arg_w_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .trans_x_o   (trans_x_o),
    .trans_y_o   (trans_y_o),
    .trans_z_o   (trans_z_o),
    .scl_x_o     (scl_x_o),
    .scl_y_o     (scl_y_o),
    .scl_z_o     (scl_z_o),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o),
    .rot_w_o     (rot_w_o),
    .overflow_o  (overflow_o)
  );

  // model state of the accumulated transform
  word_t  pos[3];
  word_t  scl[3];
  word_t  quat[4];   // x, y, z, w
  logic   clamp_hit;

  xform_t pending_xforms[$];

  bit     idle_enable  = 1'b1;
  int     fail_count   = 0;
  int     report_count = 0;
  int     checked      = 0;
  int     sat_items    = 0;
  int     op_count[4]  = '{0, 0, 0, 0};
  int     cycle_count  = 0;

  // ---------------------------------------------------------------------------
  // clock, watchdog

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_xforms.size());
      $display("tb_transform_accumulator_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // fixed-point model: exact products, at most one round-half-up per sum, then clamp

  function automatic wide_t widen(input word_t v);
    widen = v;
  endfunction

  function automatic wide_t prod(input word_t a, input word_t b);
    wide_t l, r;
    l = a;
    r = b;
    return l * r;
  endfunction

  function automatic wide_t round_half_up(input wide_t s, input int k);
    wide_t half;
    half = 1;
    half = half <<< (k - 1);
    return (s + half) >>> k;
  endfunction

  function automatic word_t saturate(input wide_t v);
    wide_t hi_lim, lo_lim;
    hi_lim = 1;
    hi_lim = (hi_lim <<< (SAT_W - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) begin
      clamp_hit = 1'b1;
      return word_t'(hi_lim);
    end else if (v < lo_lim) begin
      clamp_hit = 1'b1;
      return word_t'(lo_lim);
    end
    return word_t'(v);
  endfunction

  // apply one accepted input transaction to the model and queue the result it must produce
  task automatic advance_transform(input logic [1:0] fn, input word_t ax, input word_t ay,
                                   input word_t az, input word_t aw);
    word_t  bx, by, bz, bw, vx, vy, vz, tx, ty, tz;
    word_t  gain[3];
    xform_t e;
    clamp_hit = 1'b0;
    case (fn)
      FUNC_TRANSLATE: begin
        pos[0] = saturate(widen(pos[0]) + widen(ax));
        pos[1] = saturate(widen(pos[1]) + widen(ay));
        pos[2] = saturate(widen(pos[2]) + widen(az));
      end
      FUNC_SCALE: begin
        gain[0] = ax;
        gain[1] = ay;
        gain[2] = az;
        for (int i = 0; i < 3; i++) begin
          pos[i] = saturate(round_half_up(prod(pos[i], gain[i]), SHIFT_TS));
          scl[i] = saturate(round_half_up(prod(scl[i], gain[i]), SHIFT_TS));
        end
      end
      FUNC_ROTATE: begin
        bx = quat[0]; by = quat[1]; bz = quat[2]; bw = quat[3];
        vx = pos[0];  vy = pos[1];  vz = pos[2];
        // new quaternion times old
        quat[0] = saturate(round_half_up(prod(aw, bx) + prod(ax, bw) + prod(ay, bz)
                                         - prod(az, by), SHIFT_ROT));
        quat[1] = saturate(round_half_up(prod(aw, by) - prod(ax, bz) + prod(ay, bw)
                                         + prod(az, bx), SHIFT_ROT));
        quat[2] = saturate(round_half_up(prod(aw, bz) + prod(ax, by) - prod(ay, bx)
                                         + prod(az, bw), SHIFT_ROT));
        quat[3] = saturate(round_half_up(prod(aw, bw) - prod(ax, bx) - prod(ay, by)
                                         - prod(az, bz), SHIFT_ROT));
        // t = 2 (q x v), the factor two folded into the rounding point
        tx = saturate(round_half_up(prod(ay, vz) - prod(az, vy), SHIFT_T));
        ty = saturate(round_half_up(prod(az, vx) - prod(ax, vz), SHIFT_T));
        tz = saturate(round_half_up(prod(ax, vy) - prod(ay, vx), SHIFT_T));
        // v + w t + q x t
        pos[0] = saturate(widen(vx) + round_half_up(prod(aw, tx) + prod(ay, tz)
                                                    - prod(az, ty), SHIFT_ROT));
        pos[1] = saturate(widen(vy) + round_half_up(prod(aw, ty) + prod(az, tx)
                                                    - prod(ax, tz), SHIFT_ROT));
        pos[2] = saturate(widen(vz) + round_half_up(prod(aw, tz) + prod(ax, ty)
                                                    - prod(ay, tx), SHIFT_ROT));
      end
      default: ;  // unused code leaves the transform alone
    endcase
    for (int i = 0; i < 3; i++) begin
      e.word[i]     = pos[i];
      e.word[3 + i] = scl[i];
    end
    for (int i = 0; i < 4; i++) e.word[6 + i] = quat[i];
    e.ovf = clamp_hit;
    if (clamp_hit) sat_items++;
    pending_xforms.push_back(e);
  endtask

  // ---------------------------------------------------------------------------
  // input side: optional idle cycles, then hold the transaction until it is taken

  task automatic send_op(input logic [1:0] fn, input word_t ax, input word_t ay,
                         input word_t az, input word_t aw);
    while (idle_enable && $urandom_range(99) < 17) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    func_i     = fn;
    arg_x_i    = ax;
    arg_y_i    = ay;
    arg_z_i    = az;
    arg_w_i    = aw;
    do @(posedge clk_i); while (in_stall_o);
    advance_transform(fn, ax, ay, az, aw);
    op_count[fn]++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, and a check of every result transaction

  always @(negedge clk_i) begin
    out_stall_i <= idle_enable && ($urandom_range(99) < 17);
  end

  always @(posedge clk_i) begin : result_check
    xform_t      got, want;
    logic [31:0] exp_v, act_v;
    int          i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.word[0] = trans_x_o;
      got.word[1] = trans_y_o;
      got.word[2] = trans_z_o;
      got.word[3] = scl_x_o;
      got.word[4] = scl_y_o;
      got.word[5] = scl_z_o;
      got.word[6] = rot_x_o;
      got.word[7] = rot_y_o;
      got.word[8] = rot_z_o;
      got.word[9] = rot_w_o;
      got.ovf     = overflow_o;
      if (pending_xforms.size() == 0) begin
        fail_count++;
        report_count++;
        if (report_count <= REPORT_MAX)
          $display("%0t: result transaction with nothing expected", $realtime);
      end else begin
        want = pending_xforms.pop_front();
        checked++;
        for (i = 0; i < 11; i++) begin
          exp_v = (i < 10) ? want.word[i] : {31'd0, want.ovf};
          act_v = (i < 10) ? got.word[i]  : {31'd0, got.ovf};
          if (exp_v !== act_v) begin
            fail_count++;
            report_count++;
            if (report_count <= REPORT_MAX)
              $display("%0t: result %0d %s expected %h got %h", $realtime, checked,
                       field_names[i], exp_v, act_v);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic real rand_real(input real lo, input real hi);
    return lo + (hi - lo) * real'($urandom_range(1000000)) / 1.0e6;
  endfunction

  function automatic word_t to_fixed(input real v, input int frac);
    return word_t'($rtoi(v * (2.0 ** frac)));
  endfunction

  // ---------------------------------------------------------------------------
  // directed tests

  // reset state comes out untouched by the no-op code; translate ignores arg_w
  task automatic test_unused_code;
    send_op(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
    send_op(FUNC_TRANSLATE, ONE_TS, 2 * ONE_TS, -3 * ONE_TS, $urandom);
  endtask

  // translation clamps at both ends and recovers
  task automatic test_translate_extremes;
    send_op(FUNC_TRANSLATE, W_MAX, W_MIN, '0, W_MAX);
    send_op(FUNC_TRANSLATE, W_MAX, W_MIN, W_MIN, W_MIN);
    send_op(FUNC_TRANSLATE, W_MIN, W_MAX, W_MAX, '0);
    send_op(FUNC_TRANSLATE, ONE_TS, ONE_TS, ONE_TS, W_MAX);
  endtask

  // negative, huge and tiny gains; scale and translation both clamp
  task automatic test_scale_extremes;
    send_op(FUNC_SCALE, -ONE_TS, 2 * ONE_TS, ONE_TS / 2, W_MIN);
    send_op(FUNC_SCALE, W_MAX, W_MAX, W_MAX, '0);
    send_op(FUNC_SCALE, W_MIN, W_MIN, W_MIN, W_MAX);
    send_op(FUNC_SCALE, 32'sd1, 32'sd2, -32'sd2, $urandom);
    send_op(FUNC_SCALE, ONE_TS, -ONE_TS, ONE_TS, $urandom);
  endtask

  // identity, quarter turn, half turn with w zero, non-unit quaternions and recovery
  task automatic test_rotation_cases;
    send_op(FUNC_TRANSLATE, 3 * ONE_TS, -2 * ONE_TS, ONE_TS / 2, '0);
    send_op(FUNC_ROTATE, '0, '0, '0, ONE_ROT);
    send_op(FUNC_ROTATE, '0, '0, Q45, Q45);
    send_op(FUNC_ROTATE, ONE_ROT, '0, '0, '0);
    send_op(FUNC_ROTATE, W_MAX, W_MIN, W_MAX, W_MIN);
    send_op(FUNC_ROTATE, W_MIN, W_MIN, W_MIN, W_MIN);
    // shrink the oversized quaternion back toward unit length
    send_op(FUNC_ROTATE, '0, '0, '0, ONE_ROT / 2);
    send_op(FUNC_ROTATE, '0, '0, '0, ONE_ROT / 2);
  endtask

  // zero gain and zero quaternion are absorbing, so they run last
  task automatic test_zero_absorbing;
    send_op(FUNC_SCALE, '0, '0, '0, $urandom);
    send_op(FUNC_ROTATE, '0, '0, '0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // random operations: mostly plausible transforms, some raw full-range noise

  task automatic test_random_ops(input int n, input bit no_idle);
    logic [1:0] fn;
    word_t      a[4];
    real        q[4];
    real        norm, factor, sgn;
    int         pick, k, i;
    idle_enable = !no_idle;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      for (i = 0; i < 4; i++) a[i] = $urandom;
      if (pick < 15) begin
        fn = 2'($urandom_range(3));
      end else if (pick < 20) begin
        fn = FUNC_UNUSED;
      end else if (pick < 55) begin
        fn = FUNC_TRANSLATE;
        for (i = 0; i < 3; i++) a[i] = to_fixed(rand_real(-500.0, 500.0), SHIFT_TS);
      end else if (pick < 78) begin
        // log-uniform gain between one half and two keeps the scale from drifting off
        fn = FUNC_SCALE;
        for (i = 0; i < 3; i++) begin
          sgn  = ($urandom_range(4) == 0) ? -1.0 : 1.0;
          a[i] = to_fixed(sgn * $pow(2.0, rand_real(-1.0, 1.0)), SHIFT_TS);
        end
      end else begin
        // unit quaternion, now and then stretched or shrunk
        fn = FUNC_ROTATE;
        for (i = 0; i < 4; i++) q[i] = rand_real(-1.0, 1.0);
        norm = $sqrt(q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3]);
        if (norm < 0.01) begin
          q[0] = 0.0; q[1] = 0.0; q[2] = 0.0; q[3] = 1.0;
          norm = 1.0;
        end
        factor = ($urandom_range(9) == 0) ? rand_real(0.5, 1.5) : 1.0;
        for (i = 0; i < 4; i++) a[i] = to_fixed(q[i] * factor / norm, SHIFT_ROT);
      end
      send_op(fn, a[0], a[1], a[2], a[3]);
    end
    idle_enable = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin
    // model starts from the identity, as the block does after reset
    for (int i = 0; i < 3; i++) begin
      pos[i] = '0;
      scl[i] = ONE_TS;
    end
    quat[0] = '0;
    quat[1] = '0;
    quat[2] = '0;
    quat[3] = ONE_ROT;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unused_code();
    test_translate_extremes();
    test_scale_extremes();
    test_rotation_cases();
    // a long stretch with neither side idling, then the rest with random gaps
    test_random_ops(300, 1'b1);
    test_random_ops(850, 1'b0);
    test_zero_absorbing();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_xforms.size() != 0) @(posedge clk_i);
    // the longest operation is a rotate, so give it that long to show any stray result
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_xforms.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", pending_xforms.size());
    end

    $display("ran %0d translate, %0d scale, %0d rotate and %0d no-op transactions",
             op_count[FUNC_TRANSLATE], op_count[FUNC_SCALE], op_count[FUNC_ROTATE],
             op_count[FUNC_UNUSED]);
    $display("%0d results checked, %0d of them saturated, %0d mismatches",
             checked, sat_items, fail_count);
    if (fail_count == 0) begin
      $display("tb_transform_accumulator_top passed");
    end else begin
      $display("tb_transform_accumulator_top failed");
    end
    $finish;
  end

endmodule
